FILE: sv/lrfs_pkg.sv
// ----------------------------------------------------------------------------
// lrfs_pkg
// Shared constants, widths and tables of the repulsive field summer.
// ----------------------------------------------------------------------------
package lrfs_pkg;

  localparam int MAX_BEAMS    = 1024;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;

  localparam int BIDX_W   = $clog2(MAX_BEAMS + 1);
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ANG_W    = 16;
  localparam int RANGE_W  = 16;
  localparam int OUT_W    = 16;

  localparam int CS_W     = 34;  // CORDIC x/y/z datapath, Q2.30 plus headroom
  localparam int ITER_W   = $clog2(ATAN_ENTRIES);
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam int DEN_W    = 33;  // range^2 + 65536
  localparam int REM_W    = 34;
  localparam int RQ_W     = 32;  // reciprocal quotient, top bit always zero
  localparam int W_W      = 31;  // weight 1/(1+d^2) in Q1.30
  localparam int RCYC     = RQ_W / 2;
  localparam int RCNT_W   = $clog2(RCYC);

  localparam int ACC_W    = 28;
  localparam int PROD_W   = 64;
  localparam int TERM_W   = 20;

  localparam int MNUM_W   = ACC_W + 1;
  localparam int MDEN_W   = BIDX_W + 1;
  localparam int MCNT_W   = $clog2(MNUM_W);

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE   = 2'd2;

  function automatic logic signed [CS_W-1:0] atan_val(input logic [ITER_W-1:0] i);
    logic signed [CS_W-1:0] v;
    case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/lrfs_if.sv
// ----------------------------------------------------------------------------
// lrfs_in_if / lrfs_out_if
// Valid/ready channels for beam requests and push vector results.
// ----------------------------------------------------------------------------
interface lrfs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_m;
  logic        last_beam;
  modport source(output valid, range_m, last_beam, input ready);
  modport sink(input valid, range_m, last_beam, output ready);
endinterface

interface lrfs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] push_x;
  logic signed [15:0] push_y;
  modport source(output valid, push_x, push_y, input ready);
  modport sink(input valid, push_x, push_y, output ready);
endinterface

FILE: sv/lrfs_cordic.sv
// ----------------------------------------------------------------------------
// lrfs_cordic
// Iterative rotation CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module lrfs_cordic
  import lrfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [ANG_W-1:0]       angle,
  output logic                   busy,
  output logic signed [CS_W-1:0] cos_o,
  output logic signed [CS_W-1:0] sin_o
);

  logic                   busy_r, busy_nxt;
  logic [ITER_W-1:0]      i_r, i_nxt;
  logic                   flip_r, flip_nxt;
  logic signed [CS_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [ANG_W-1:0]       t;
  logic                   fl;

  always_comb begin
    fl = (angle >= 16'd16384) && (angle < 16'd49152);
    t  = fl ? angle + 16'd32768 : angle;
    busy_nxt = busy_r;
    i_nxt = i_r;
    flip_nxt = flip_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (start) begin
      busy_nxt = 1'b1;
      i_nxt    = '0;
      flip_nxt = fl;
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = CS_W'($signed(t)) <<< 16;
    end else if (busy_r) begin
      if (!z_r[CS_W-1]) begin
        x_nxt = x_r - (y_r >>> i_r);
        y_nxt = y_r + (x_r >>> i_r);
        z_nxt = z_r - atan_val(i_r);
      end else begin
        x_nxt = x_r + (y_r >>> i_r);
        y_nxt = y_r - (x_r >>> i_r);
        z_nxt = z_r + atan_val(i_r);
      end
      i_nxt = i_r + 1'b1;
      if (i_r == ITER_W'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    i_r    <= i_nxt;
    flip_r <= flip_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign busy  = busy_r;
  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;

endmodule

FILE: sv/lrfs_recip.sv
// ----------------------------------------------------------------------------
// lrfs_recip
// Radix-4 restoring divider for the weight 2^46 / (range^2 + 65536).
// ----------------------------------------------------------------------------
module lrfs_recip
  import lrfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RANGE_W-1:0] range_m,
  output logic               busy,
  output logic [W_W-1:0]     weight
);

  logic              busy_r, busy_nxt;
  logic [RCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [RQ_W-1:0]   q_r, q_nxt;
  logic [REM_W-1:0]  rt;
  logic [RQ_W-1:0]   qt;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    rt = rem_r;
    qt = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = DEN_W'(range_m * range_m) + DEN_W'(65536);
      rem_nxt  = REM_W'(16384);
      q_nxt    = '0;
    end else if (busy_r) begin
      for (int k = 0; k < 2; k++) begin
        rt = {rt[REM_W-2:0], 1'b0};
        qt = {qt[RQ_W-2:0], 1'b0};
        if (rt >= REM_W'(den_r)) begin
          rt = rt - REM_W'(den_r);
          qt[0] = 1'b1;
        end
      end
      rem_nxt = rt;
      q_nxt   = qt;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == RCNT_W'(RCYC - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign busy   = busy_r;
  assign weight = q_r[W_W-1:0];

endmodule

FILE: sv/lrfs_mean_div.sv
// ----------------------------------------------------------------------------
// lrfs_mean_div
// Bit-serial restoring divider for the scan mean.
// ----------------------------------------------------------------------------
module lrfs_mean_div
  import lrfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MNUM_W-1:0] num,
  input  logic [MDEN_W-1:0] den,
  output logic              busy,
  output logic [MNUM_W-1:0] quot
);

  logic              busy_r, busy_nxt;
  logic [MCNT_W-1:0] cnt_r, cnt_nxt;
  logic [MDEN_W-1:0] den_r, den_nxt;
  logic [MDEN_W:0]   rem_r, rem_nxt;
  logic [MNUM_W-1:0] q_r, q_nxt;
  logic [MDEN_W:0]   rt;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    rt = {rem_r[MDEN_W-1:0], q_r[MNUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = den;
      rem_nxt  = '0;
      q_nxt    = num;
    end else if (busy_r) begin
      if (rt >= {1'b0, den_r}) begin
        rem_nxt = rt - {1'b0, den_r};
        q_nxt   = {q_r[MNUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rt;
        q_nxt   = {q_r[MNUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MCNT_W'(MNUM_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

FILE: sv/lidar_repulsive_field_sum.sv
// ----------------------------------------------------------------------------
// lidar_repulsive_field_sum
// Sums the repulsive push of one lidar scan and emits its mean per scan.
// ----------------------------------------------------------------------------
// Each beam request carries one range (unsigned Q8.8 meters). A beam at or
// above min_range is turned into a direction by an iterative CORDIC (one
// micro-rotation per cycle, 16 steps) while a radix-4 divider forms the weight
// 1/(1+d^2) alongside it; one shared 34x17 multiplier then forms the x and y
// terms in four passes. A skipped beam does not leave the idle state unless it
// closes the scan; the last beam of a scan adds two serial divisions for the
// mean, one for x and then one for y. The input is not ready while a beam is
// being worked on. The finished push vector sits in an output register, so
// the next scan may start while it waits to be taken. Configuration writes
// take effect with the next beam.
module lidar_repulsive_field_sum
  import lrfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  lrfs_in_if.sink              in_ch,
  lrfs_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CALC = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIVX = 6'b001000,
    S_DIVY = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [ANG_W-1:0]   angle_start_r, angle_step_r;
  logic [RANGE_W-1:0] min_range_r;
  logic [BIDX_W-1:0]  beam_index_r, beam_index_nxt;
  logic signed [ACC_W-1:0] sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic               last_r, last_nxt;
  logic [2:0]         mcnt_r, mcnt_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [MNUM_W-1:0]  qx_r, qx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] push_x_r, push_x_nxt, push_y_r, push_y_nxt;

  logic               accept, count_en, use_beam;
  logic [ANG_W-1:0]   angle;
  logic               cordic_busy, recip_busy, div_busy, div_start;
  logic signed [CS_W-1:0] cos_v, sin_v;
  logic [W_W-1:0]     weight;
  logic [MNUM_W-1:0]  div_num, div_quot;
  logic signed [ACC_W-1:0] div_sum;
  logic [ACC_W-1:0]   div_mag;
  logic signed [CS_W-1:0]  mul_a;
  logic [16:0]        mul_b;
  logic signed [CS_W+17-1:0] pp;
  logic signed [TERM_W-1:0]  term;
  logic signed [ACC_W+1:0]   acc_base, acc_diff;
  logic signed [ACC_W-1:0]   acc_sat;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_start_r <= 16'd32768;
      angle_step_r  <= 16'd256;
      min_range_r   <= 16'd51;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_START: angle_start_r <= cfg_wdata;
        CFG_ANGLE_STEP:  angle_step_r  <= cfg_wdata;
        CFG_MIN_RANGE:   min_range_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  // Beams past MAX_BEAMS in one scan are neither counted nor summed.
  assign count_en    = (beam_index_r < BIDX_W'(MAX_BEAMS));
  assign use_beam    = count_en && (in_ch.range_m >= min_range_r);
  assign angle       = angle_start_r
                     + ANG_W'(beam_index_r * angle_step_r);

  lrfs_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(accept && use_beam), .angle(angle),
    .busy(cordic_busy), .cos_o(cos_v), .sin_o(sin_v)
  );

  lrfs_recip u_recip (
    .clk(clk), .rst_n(rst_n), .start(accept && use_beam), .range_m(in_ch.range_m),
    .busy(recip_busy), .weight(weight)
  );

  // Shared multiplier: passes 0/1 form cos*w, passes 2/3 form sin*w, each
  // weight split into a low 16-bit and a high 15-bit half.
  assign mul_a = mcnt_r[1] ? sin_v : cos_v;
  assign mul_b = mcnt_r[0] ? {2'b00, weight[W_W-1:16]} : {1'b0, weight[15:0]};
  assign pp    = mul_a * $signed(mul_b);

  // Round half up, then take the Q.16 term off the accumulator with saturation.
  assign term     = TERM_W'((prod_r + (64'sd1 <<< 43)) >>> 44);
  assign acc_base = (mcnt_r == 3'd2) ? (ACC_W+2)'(sum_x_r) : (ACC_W+2)'(sum_y_r);
  assign acc_diff = acc_base - (ACC_W+2)'(term);
  always_comb begin
    if (acc_diff > (ACC_W+2)'(134217727)) begin
      acc_sat = ACC_W'(134217727);
    end else if (acc_diff < -(ACC_W+2)'(134217728)) begin
      acc_sat = -ACC_W'(134217728) ;
    end else begin
      acc_sat = acc_diff[ACC_W-1:0];
    end
  end

  // Mean divider: x is started when the scan closes, y when x finishes.
  assign div_sum = (state_r == S_DIVX) ? sum_y_r : sum_x_r;
  assign div_mag = div_sum[ACC_W-1] ? ACC_W'(-div_sum) : ACC_W'(div_sum);
  assign div_num = MNUM_W'(div_mag) + MNUM_W'(beam_index_nxt);
  assign div_start = (accept && in_ch.last_beam && !use_beam)
                   || ((state_r == S_MUL) && (mcnt_r == 3'd4) && last_r)
                   || ((state_r == S_DIVX) && !div_busy);

  lrfs_mean_div u_mean_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den({beam_index_nxt, 1'b0}), .busy(div_busy), .quot(div_quot)
  );

  function automatic logic signed [OUT_W-1:0] sat_out(input logic neg,
                                                      input logic [MNUM_W-1:0] q);
    logic signed [OUT_W-1:0] r;
    if (neg) begin
      r = (q > MNUM_W'(32768)) ? 16'sh8000 : -$signed(q[OUT_W-1:0]);
    end else begin
      r = (q > MNUM_W'(32767)) ? 16'sh7fff : $signed(q[OUT_W-1:0]);
    end
    return r;
  endfunction

  always_comb begin
    state_nxt      = state_r;
    beam_index_nxt = beam_index_r;
    sum_x_nxt      = sum_x_r;
    sum_y_nxt      = sum_y_r;
    last_nxt       = last_r;
    mcnt_nxt       = mcnt_r;
    prod_nxt       = prod_r;
    qx_nxt         = qx_r;
    out_valid_nxt  = out_valid_r;
    push_x_nxt     = push_x_r;
    push_y_nxt     = push_y_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_ch.last_beam;
          if (count_en) begin
            beam_index_nxt = beam_index_r + 1'b1;
          end
          if (use_beam) begin
            state_nxt = S_CALC;
          end else if (in_ch.last_beam) begin
            state_nxt = S_DIVX;
          end
        end
      end
      S_CALC: begin
        mcnt_nxt = '0;
        if (!cordic_busy && !recip_busy) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mcnt_nxt = mcnt_r + 1'b1;
        case (mcnt_r)
          3'd0: prod_nxt = PROD_W'(pp);
          3'd1: prod_nxt = prod_r + (PROD_W'(pp) <<< 16);
          3'd2: begin
            sum_x_nxt = acc_sat;
            prod_nxt  = PROD_W'(pp);
          end
          3'd3: prod_nxt = prod_r + (PROD_W'(pp) <<< 16);
          default: begin
            sum_y_nxt = acc_sat;
            state_nxt = last_r ? S_DIVX : S_IDLE;
          end
        endcase
      end
      S_DIVX: begin
        if (!div_busy) begin
          qx_nxt    = div_quot;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (!div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          push_x_nxt     = sat_out(sum_x_r[ACC_W-1], qx_r);
          push_y_nxt     = sat_out(sum_y_r[ACC_W-1], div_quot);
          beam_index_nxt = '0;
          sum_x_nxt      = '0;
          sum_y_nxt      = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      beam_index_r <= '0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      beam_index_r <= beam_index_nxt;
      sum_x_r      <= sum_x_nxt;
      sum_y_r      <= sum_y_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    last_r   <= last_nxt;
    mcnt_r   <= mcnt_nxt;
    prod_r   <= prod_nxt;
    qx_r     <= qx_nxt;
    push_x_r <= push_x_nxt;
    push_y_r <= push_y_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.push_x = push_x_r;
  assign out_ch.push_y = push_y_r;

`ifndef SYNTHESIS
  a_bidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    beam_index_r <= BIDX_W'(MAX_BEAMS))
    else $error("beam count above limit");
  a_units_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> !cordic_busy && !recip_busy)
    else $error("multiply started before CORDIC or weight finished");
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (use_beam || in_ch.last_beam) |=> !in_ch.ready)
    else $error("request taken while a beam is in progress");
`endif

endmodule

FILE: tb/tb_lidar_repulsive_field_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_repulsive_field_sum
// Drives lidar scans into the repulsive field summer and checks each push
// vector against a cycle-free predictor of the CORDIC, weight and mean math.
// ----------------------------------------------------------------------------
module tb_lidar_repulsive_field_sum;
  import lrfs_pkg::*;

  // Clock, reset and the configuration port.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ANGLE_START;
  logic [CFG_W-1:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  lrfs_in_if in_ch();
  lrfs_out_if out_ch();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.range_m = '0;
    in_ch.last_beam = 1'b0;
    out_ch.ready = 1'b0;
  end

  lidar_repulsive_field_sum dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Idle percentages for the two sides; the hold-off flag freezes the receiver.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int unsigned errors = 0;

  // Predictor state: configuration copy and the scan accumulators.
  logic [15:0] p_angle_start = 16'd32768;
  logic [15:0] p_angle_step = 16'd256;
  logic [15:0] p_min_range = 16'd51;
  int unsigned p_beam_count = 0;
  longint p_sum_x = 0;
  longint p_sum_y = 0;

  typedef struct packed {
    logic signed [15:0] push_x;
    logic signed [15:0] push_y;
  } push_t;
  push_t push_queue[$];

  longint atan_steps[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  // Floor division by a power of two; >>> on a signed longint already floors.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_acc(longint v);
    if (v > 134217727) return 134217727;
    if (v < -134217728) return -134217728;
    return v;
  endfunction

  // Direction of a beam in Q2.30, with the fold into the right half-plane.
  task automatic beam_direction(input logic [15:0] ang, output longint c,
                                output longint s);
    logic [15:0] t;
    bit flip;
    longint x, y, z, nx;
    t = ang;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (t >= 16384 && t < 49152) begin
      t = t + 16'd32768;
      flip = 1'b1;
    end
    z = (t < 16384) ? longint'(t) : longint'(t) - 65536;
    z = z * 65536;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z = z - atan_steps[i];
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z = z + atan_steps[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic signed [15:0] scan_mean(longint sum, int unsigned n);
    longint m, q;
    m = (sum < 0) ? -sum : sum;
    q = (m + n) / (2 * longint'(n));
    if (sum < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Folds one accepted beam into the scan and queues the push vector on the last.
  task automatic predict_beam(input logic [15:0] rng, input bit last);
    longint c, s, w;
    logic [15:0] ang;
    if (p_beam_count < MAX_BEAMS) begin
      if (rng >= p_min_range) begin
        ang = p_angle_start + 16'(p_beam_count) * p_angle_step;
        beam_direction(ang, c, s);
        w = (longint'(1) << 46) / (longint'(rng) * rng + 65536);
        p_sum_x = clamp_acc(p_sum_x - floor_shift(c * w + (longint'(1) << 43), 44));
        p_sum_y = clamp_acc(p_sum_y - floor_shift(s * w + (longint'(1) << 43), 44));
      end
      p_beam_count++;
    end
    if (last) begin
      push_queue.push_back({scan_mean(p_sum_x, p_beam_count),
                            scan_mean(p_sum_y, p_beam_count)});
      p_beam_count = 0;
      p_sum_x = 0;
      p_sum_y = 0;
    end
  endtask

  // Sends one beam request, idling before it at the sender's rate, and predicts
  // it once the handshake has completed. Valid stays high until the next
  // request, an idle cycle or the drain drops it.
  task automatic send_beam(input logic [15:0] rng, input bit last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.range_m <= rng;
    in_ch.last_beam <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_beam(rng, last);
  endtask

  // Receiver: randomly stalls, or holds off completely while hold_off is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: compares each accepted push vector with the oldest one queued.
  always @(posedge clk) begin
    push_t exp_push;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (push_queue.size() == 0) begin
        $error("unexpected push vector x=%0d y=%0d", out_ch.push_x, out_ch.push_y);
        errors++;
      end else begin
        exp_push = push_queue.pop_front();
        if (out_ch.push_x !== exp_push.push_x) begin
          $error("push_x expected %0d actual %0d", exp_push.push_x, out_ch.push_x);
          errors++;
        end
        if (out_ch.push_y !== exp_push.push_y) begin
          $error("push_y expected %0d actual %0d", exp_push.push_y, out_ch.push_y);
          errors++;
        end
      end
    end
  end

  // Drops the request, then waits for all results plus the tail of a last-beam
  // mean division, since a skipped beam may still be in flight when the queue
  // empties.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (push_queue.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Register writes happen only with the block idle; the predictor follows.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ANGLE_START: p_angle_start = val;
      CFG_ANGLE_STEP: p_angle_step = val;
      CFG_MIN_RANGE: p_min_range = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [15:0] random_range();
    case ($urandom_range(5))
      0: return 16'($urandom_range(0, 80));
      1: return 16'($urandom_range(65535));
      2: return 16'($urandom_range(60000, 65535));
      default: return 16'($urandom_range(40, 1200));
    endcase
  endfunction

  // Sends a scan of n beams with random ranges, closed by a last beam.
  task automatic send_scan(input int n);
    for (int i = 0; i < n; i++) send_beam(random_range(), i == n - 1);
  endtask

  // Directed extremes at reset configuration: zero range (skipped), the
  // minimum boundary, tiny and huge ranges, single-beam scans.
  task automatic test_directed_ranges();
    send_beam(16'd0, 1'b1);
    send_beam(16'd50, 1'b0);
    send_beam(16'd51, 1'b1);
    send_beam(16'd65535, 1'b1);
    send_beam(16'd51, 1'b0);
    send_beam(16'd52, 1'b0);
    send_beam(16'd256, 1'b0);
    send_beam(16'hAAAA, 1'b0);
    send_beam(16'h5555, 1'b1);
    drain();
  endtask

  // Configuration extremes: every quadrant fold, a zero step, a full-scale
  // step and min_range at both ends: zero uses every beam, 65535 only the top range.
  task automatic test_config_extremes();
    write_reg(CFG_MIN_RANGE, 16'd0);
    write_reg(CFG_ANGLE_STEP, 16'd16384);
    write_reg(CFG_ANGLE_START, 16'd0);
    for (int i = 0; i < 8; i++) send_beam(16'd0, i == 7);
    drain();
    write_reg(CFG_ANGLE_START, 16'd65535);
    write_reg(CFG_ANGLE_STEP, 16'd65535);
    send_scan(4);
    drain();
    write_reg(CFG_ANGLE_STEP, 16'd0);
    write_reg(CFG_ANGLE_START, 16'd16384);
    send_scan(3);
    drain();
    write_reg(CFG_MIN_RANGE, 16'd65535);
    send_beam(16'd65534, 1'b0);
    send_beam(16'd65535, 1'b1);
    drain();
  endtask

  // A scan longer than MAX_BEAMS: beams past the limit are neither counted
  // nor accumulated, and the closing beam still yields a result.
  task automatic test_beam_overflow();
    write_reg(CFG_MIN_RANGE, 16'd51);
    write_reg(CFG_ANGLE_STEP, 16'd61);
    write_reg(CFG_ANGLE_START, 16'd32768);
    for (int i = 0; i < MAX_BEAMS + 2; i++) send_beam(16'd0, i == MAX_BEAMS + 1);
    drain();
  endtask

  // Random scans under one idling phase, with a fresh random configuration.
  task automatic test_random_scans(input int unsigned send_pct,
                                   input int unsigned recv_pct, input int beams);
    int sent;
    write_reg(CFG_ANGLE_START, 16'($urandom_range(65535)));
    write_reg(CFG_ANGLE_STEP, 16'($urandom_range(65535)));
    write_reg(CFG_MIN_RANGE, 16'($urandom_range(0, 300)));
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < beams) begin
      automatic int n = ($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 6);
      send_scan(n);
      sent += n;
    end
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // The receiver holds off for a long stretch while short scans keep coming,
  // so the output register fills and the input stalls.
  task automatic test_output_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_scan(1 + (i % 3));
    join
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ranges();
    test_config_extremes();
    test_beam_overflow();
    test_random_scans(0, 0, 40);
    test_random_scans(47, 0, 40);
    test_random_scans(0, 47, 40);
    test_random_scans(8, 8, 40);
    test_output_backpressure();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog far above the slowest correct run of about 1300 beams.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: lidar_repulsive_field_sum.f
sv/lrfs_pkg.sv
sv/lrfs_if.sv
sv/lrfs_cordic.sv
sv/lrfs_recip.sv
sv/lrfs_mean_div.sv
sv/lidar_repulsive_field_sum.sv
tb/tb_lidar_repulsive_field_sum.sv
